[hdl/ctv_pkg.sv]
// Shared types and constants of the coordinate text validator.
package ctv_pkg;

    // Character classes sent from the front to the back
    typedef enum logic [2:0] {
        CC_DIGIT = 3'd0,
        CC_DOT   = 3'd1,
        CC_DASH  = 3'd2,
        CC_NS    = 3'd3,
        CC_EW    = 3'd4,
        CC_COMMA = 3'd5,
        CC_SPACE = 3'd6,
        CC_OTHER = 3'd7
    } t_char_cls;

    // One classified item as it waits between front and back
    typedef struct packed {
        t_char_cls cls;
        logic      has_char;
        logic      last_char;
    } t_item;

    // Match classes
    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_HEMI = 2'd1;
    localparam logic [1:0] CLASS_PAIR = 2'd2;

    // Pattern mode values
    localparam logic MODE_TOLERANT = 1'b0;
    localparam logic MODE_COMPACT  = 1'b1;

    // Maximum dashes in one coordinate
    localparam logic [1:0] MAX_DASHES = 2'd2;

    // Default queue depths
    localparam int ITEM_QUEUE_DEPTH   = 2;
    localparam int RESULT_QUEUE_DEPTH = 2;

endpackage

[hdl/ctv_fifo.sv]
// Small first-word-fall-through queue built from registers.
module ctv_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_fire;
    logic             rd_fire;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_fire   = i_wr_en && !o_full;
    assign rd_fire   = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Advance pointers with wrap and track the fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_fire) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_fire) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_fire && !rd_fire) begin
            n_count = r_count + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming entry
    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

[hdl/ctv_front.sv]
// Front end: accepts characters, classifies them and queues them for the parser.
module ctv_front #(
    parameter int DEPTH = ctv_pkg::ITEM_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [15:0]   i_text_char,
    input  logic          i_has_char,
    input  logic          i_last_char,
    input  logic          i_pop,
    output ctv_pkg::t_item o_item,
    output logic          o_empty
);

    ctv_pkg::t_item in_item;
    logic [$bits(ctv_pkg::t_item)-1:0] rd_bits;

    function automatic ctv_pkg::t_char_cls classify(input logic [15:0] c);
        ctv_pkg::t_char_cls k;
        k = ctv_pkg::CC_OTHER;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            k = ctv_pkg::CC_DIGIT;
        end else if (c == 16'h002E) begin
            k = ctv_pkg::CC_DOT;
        end else if (c == 16'h002D) begin
            k = ctv_pkg::CC_DASH;
        end else if (c == 16'h002C) begin
            k = ctv_pkg::CC_COMMA;
        end else if (c == 16'h004E || c == 16'h0053 || c == 16'h006E || c == 16'h0073) begin
            k = ctv_pkg::CC_NS;
        end else if (c == 16'h0045 || c == 16'h0057 || c == 16'h0065 || c == 16'h0077) begin
            k = ctv_pkg::CC_EW;
        end else if (c == 16'h0020 || (c >= 16'h0009 && c <= 16'h000D)) begin
            k = ctv_pkg::CC_SPACE;
        end
        return k;
    endfunction

    // Reduce the code unit to its class
    always_comb begin
        in_item.cls       = classify(i_text_char);
        in_item.has_char  = i_has_char;
        in_item.last_char = i_last_char;
    end

    ctv_fifo #(
        .WIDTH ($bits(ctv_pkg::t_item)),
        .DEPTH (DEPTH)
    ) u_item_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_push),
        .i_wr_data (in_item),
        .o_full    (o_full),
        .i_rd_en   (i_pop),
        .o_rd_data (rd_bits),
        .o_empty   (o_empty)
    );

    assign o_item = ctv_pkg::t_item'(rd_bits);

endmodule

[hdl/ctv_back.sv]
// Back end: steps the pattern automaton and emits a class at each string end.
module ctv_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_mode,
    input  ctv_pkg::t_item i_item,
    input  logic           i_item_valid,
    output logic           o_item_pop,
    input  logic           i_res_full,
    output logic           o_res_push,
    output logic [1:0]     o_res_class
);

    typedef enum logic [9:0] {
        POS_START   = 10'b00_0000_0001,
        POS_INT     = 10'b00_0000_0010,
        POS_FRAC    = 10'b00_0000_0100,
        POS_GAP     = 10'b00_0000_1000,
        POS_HEMI    = 10'b00_0001_0000,
        POS_COMMA   = 10'b00_0010_0000,
        POS_DONE    = 10'b00_0100_0000,
        POS_P_START = 10'b00_1000_0000,
        POS_P_INT   = 10'b01_0000_0000,
        POS_P_FRAC  = 10'b10_0000_0000
    } t_pos;

    typedef struct packed {
        t_pos       pos;
        logic [1:0] dash;
        logic       second;
        logic       failed;
    } t_walk;

    t_walk r_walk, n_walk;
    logic  take;
    logic  tol;
    logic  ws;
    t_walk step;

    // Handle the character after a complete number group: a dash, hemisphere letter or comma may go on, else fail
    function automatic t_walk after_group(input t_walk w, input ctv_pkg::t_char_cls c,
                                          input logic tl);
        t_walk v;
        v = w;
        if (c == ctv_pkg::CC_DASH && w.dash < ctv_pkg::MAX_DASHES) begin
            v.dash = w.dash + 1'b1;
            v.pos  = POS_START;
        end else if (c == ctv_pkg::CC_NS && !w.second) begin
            v.second = 1'b1;
            v.dash   = 2'd0;
            v.pos    = POS_HEMI;
        end else if (c == ctv_pkg::CC_EW && w.second) begin
            v.pos = POS_DONE;
        end else if (c == ctv_pkg::CC_COMMA && !tl && !w.second) begin
            v.second = 1'b1;
            v.dash   = 2'd0;
            v.pos    = POS_P_START;
        end else begin
            v.failed = 1'b1;
        end
        return v;
    endfunction

    assign take       = i_item_valid && !i_res_full;
    assign o_item_pop = take;
    assign tol        = (i_mode == ctv_pkg::MODE_TOLERANT);
    assign ws         = tol && (i_item.cls == ctv_pkg::CC_SPACE);

    // Advance the automaton by one character
    always_comb begin
        step = r_walk;
        if (!r_walk.failed) begin
            unique case (r_walk.pos)
                POS_START, POS_COMMA: begin
                    if (i_item.cls == ctv_pkg::CC_DIGIT) step.pos = POS_INT;
                    else if (!ws) step.failed = 1'b1;
                end
                POS_INT, POS_FRAC: begin
                    if (i_item.cls == ctv_pkg::CC_DIGIT) begin
                        step = r_walk;
                    end else if (i_item.cls == ctv_pkg::CC_DOT && r_walk.pos == POS_INT) begin
                        step.pos = POS_FRAC;
                    end else if (ws) begin
                        step.pos = POS_GAP;
                    end else begin
                        step = after_group(r_walk, i_item.cls, tol);
                    end
                end
                POS_GAP: begin
                    if (!ws) step = after_group(r_walk, i_item.cls, tol);
                end
                POS_HEMI: begin
                    if (i_item.cls == ctv_pkg::CC_COMMA) step.pos = POS_COMMA;
                    else if (i_item.cls == ctv_pkg::CC_DIGIT) step.pos = POS_INT;
                    else if (!ws) step.failed = 1'b1;
                end
                POS_DONE: begin
                    if (!ws) step.failed = 1'b1;
                end
                POS_P_START: begin
                    if (i_item.cls == ctv_pkg::CC_DIGIT) step.pos = POS_P_INT;
                    else step.failed = 1'b1;
                end
                POS_P_INT, POS_P_FRAC: begin
                    if (i_item.cls == ctv_pkg::CC_DIGIT) begin
                        step = r_walk;
                    end else if (i_item.cls == ctv_pkg::CC_DOT && r_walk.pos == POS_P_INT) begin
                        step.pos = POS_P_FRAC;
                    end else if (i_item.cls == ctv_pkg::CC_DASH &&
                                 r_walk.dash < ctv_pkg::MAX_DASHES) begin
                        step.dash = r_walk.dash + 1'b1;
                        step.pos  = POS_P_START;
                    end else begin
                        step.failed = 1'b1;
                    end
                end
                default: begin
                    step.failed = 1'b1;
                end
            endcase
        end
    end

    // Commit the step for an item with a character, report the class on the last item and clear for the next string
    always_comb begin
        n_walk      = r_walk;
        o_res_push  = 1'b0;
        o_res_class = ctv_pkg::CLASS_NONE;
        if (i_item.has_char) begin
            n_walk = step;
        end
        if (n_walk.failed) begin
            o_res_class = ctv_pkg::CLASS_NONE;
        end else if (n_walk.pos == POS_DONE) begin
            o_res_class = ctv_pkg::CLASS_HEMI;
        end else if (!tol && (n_walk.pos == POS_P_INT || n_walk.pos == POS_P_FRAC)) begin
            o_res_class = ctv_pkg::CLASS_PAIR;
        end
        if (i_item.last_char) begin
            o_res_push = take;
            n_walk     = '{pos: POS_START, dash: 2'd0, second: 1'b0, failed: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk <= '{pos: POS_START, dash: 2'd0, second: 1'b0, failed: 1'b0};
        end else if (take) begin
            r_walk <= n_walk;
        end
    end

endmodule

[hdl/coordinate_text_validator.sv]
// Top level of the coordinate text validator.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+----------------------------------------
//  input     | in        | push / full           | i_text_char, i_has_char, i_last_char
//  result    | out       | empty / pop           | o_match_class
//  config    | in        | i_cfg_wr_en           | i_cfg_wr_data (pattern mode)
//
// One item per cycle sustained while the result queue has room: the front classifies and queues
// a character in the cycle it is taken, and the back steps the automaton one character per cycle.
// A result shows at the result side in the cycle after its last item is taken and can be popped
// from then on.
// Synchronous active-low reset empties both queues, restarts the automaton and sets
// compact mode. A full result queue stalls the back; the item queue then fills and
// raises full, while the result side still drains as results are popped.
module coordinate_text_validator #(
    parameter int ITEM_DEPTH   = ctv_pkg::ITEM_QUEUE_DEPTH,
    parameter int RESULT_DEPTH = ctv_pkg::RESULT_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_text_char,
    input  logic        i_has_char,
    input  logic        i_last_char,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_match_class,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data
);

    logic           r_mode;
    ctv_pkg::t_item item;
    logic           item_empty;
    logic           item_pop;
    logic           res_full;
    logic           res_push;
    logic [1:0]     res_class;

    // Hold the pattern mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ctv_pkg::MODE_COMPACT;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    ctv_front #(
        .DEPTH (ITEM_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_text_char (i_text_char),
        .i_has_char  (i_has_char),
        .i_last_char (i_last_char),
        .i_pop       (item_pop),
        .o_item      (item),
        .o_empty     (item_empty)
    );

    ctv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_item       (item),
        .i_item_valid (!item_empty),
        .o_item_pop   (item_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res_class  (res_class)
    );

    ctv_fifo #(
        .WIDTH (2),
        .DEPTH (RESULT_DEPTH)
    ) u_result_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_push),
        .i_wr_data (res_class),
        .o_full    (res_full),
        .i_rd_en   (pop),
        .o_rd_data (o_match_class),
        .o_empty   (empty)
    );

endmodule

[hdl/ctv_checker.sv]
// Port-level checks of the coordinate text validator and their binding.
module ctv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_match_class
);

    // Both queues come out of reset empty
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // A waiting result never carries an undefined class
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_match_class <= ctv_pkg::CLASS_PAIR))
        else $error("result class out of range");

    // An unclaimed result stays in place
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_match_class)))
        else $error("waiting result changed");

    // The input side only fills up after an item is offered
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

endmodule

bind coordinate_text_validator ctv_checker u_ctv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_match_class (o_match_class)
);
